### design/coas_pkg.sv
// Package of shared types and constants for the CPU operand address sequencer.
package coas_pkg;

   localparam logic [15:0] PAGE_LOW_MASK  = 16'h00FF;
   localparam logic [15:0] PAGE_HIGH_MASK = 16'hFF00;

   typedef enum logic [2:0] {
      PHASE_IDLE   = 3'd0,
      PHASE_OP1    = 3'd1,
      PHASE_OP2    = 3'd2,
      PHASE_PTR_LO = 3'd3,
      PHASE_PTR_HI = 3'd4,
      PHASE_VALUE  = 3'd5
   } phase_type;

   typedef enum logic [3:0] {
      MODE_IMP = 4'd0,
      MODE_IMM = 4'd1,
      MODE_ZP  = 4'd2,
      MODE_ZPX = 4'd3,
      MODE_ZPY = 4'd4,
      MODE_REL = 4'd5,
      MODE_ABS = 4'd6,
      MODE_ABX = 4'd7,
      MODE_ABY = 4'd8,
      MODE_IND = 4'd9,
      MODE_IZX = 4'd10,
      MODE_IZY = 4'd11
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_REQUEST    = 2'd0,
      STATUS_RESOLVED   = 2'd1,
      STATUS_UNEXPECTED = 2'd2
   } status_type;

   localparam logic ACTION_START = 1'b0;

   typedef struct packed {
      phase_type   phase;
      logic [3:0]  active_mode;
      logic [15:0] fetch_pc;
      logic [15:0] pointer;
      logic [15:0] work_address;
      logic [7:0]  latched_x;
      logic [7:0]  latched_y;
   } state_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] request_address;
      logic [15:0] effective_address;
      logic [7:0]  operand_value;
      logic [7:0]  relative_offset;
      logic [15:0] next_pc;
   } result_type;

endpackage

### design/cpu_operand_address_sequencer.sv
// Top level of the CPU operand address sequencer with its state and result registers.
// The result of an item is registered and valid in the cycle after the item is accepted.
// Throughput: one item per cycle; the step logic sits between the state registers
// and the result register, and an item is taken whenever the result register is
// empty or being emptied in the same cycle.
// Reset: synchronous, active high; the sequencer returns to idle with all state zero.
module cpu_operand_address_sequencer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [3:0]  req_mode,
   input  logic [15:0] req_operand_pc,
   input  logic [7:0]  req_index_x,
   input  logic [7:0]  req_index_y,
   input  logic [7:0]  req_read_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_request_address,
   output logic [15:0] rsp_effective_address,
   output logic [7:0]  rsp_operand_value,
   output logic [7:0]  rsp_relative_offset,
   output logic [15:0] rsp_next_pc
);

   coas_pkg::state_type  state_ff;
   coas_pkg::state_type  state_in;
   coas_pkg::result_type result_ff;
   coas_pkg::result_type result_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic                 accept;

   coas_step u_step (
      .cur        (state_ff),
      .action     (req_action),
      .mode       (req_mode),
      .operand_pc (req_operand_pc),
      .index_x    (req_index_x),
      .index_y    (req_index_y),
      .read_data  (req_read_data),
      .nxt        (state_in),
      .res        (result_in)
   );

   assign req_ready    = !rsp_valid_ff || rsp_ready;
   assign accept       = req_valid && req_ready;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase        <= coas_pkg::PHASE_IDLE;
         state_ff.active_mode  <= 4'd0;
         state_ff.fetch_pc     <= 16'd0;
         state_ff.pointer      <= 16'd0;
         state_ff.work_address <= 16'd0;
         state_ff.latched_x    <= 8'd0;
         state_ff.latched_y    <= 8'd0;
         rsp_valid_ff          <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = result_ff.status;
   assign rsp_request_address   = result_ff.request_address;
   assign rsp_effective_address = result_ff.effective_address;
   assign rsp_operand_value     = result_ff.operand_value;
   assign rsp_relative_offset   = result_ff.relative_offset;
   assign rsp_next_pc           = result_ff.next_pc;

endmodule

### design/coas_step.sv
// Combinational step logic: one item against the current state gives the next state and a result.
module coas_step (
   input  coas_pkg::state_type  cur,
   input  logic                 action,
   input  logic [3:0]           mode,
   input  logic [15:0]          operand_pc,
   input  logic [7:0]           index_x,
   input  logic [7:0]           index_y,
   input  logic [7:0]           read_data,
   output coas_pkg::state_type  nxt,
   output coas_pkg::result_type res
);

   logic [15:0] data_wide;
   logic [15:0] base;
   logic [7:0]  add;
   logic [15:0] addr;
   logic [1:0]  len;

   always_comb begin
      data_wide = {8'h00, read_data};
      base      = (cur.work_address & coas_pkg::PAGE_LOW_MASK) | {read_data, 8'h00};
      add       = 8'h00;
      addr      = 16'h0000;
      len       = 2'd0;
      nxt       = cur;
      res.status            = coas_pkg::STATUS_REQUEST;
      res.request_address   = 16'h0000;
      res.effective_address = 16'h0000;
      res.operand_value     = 8'h00;
      res.relative_offset   = 8'h00;
      res.next_pc           = 16'h0000;

      if (action == coas_pkg::ACTION_START) begin
         nxt.active_mode  = mode;
         nxt.fetch_pc     = operand_pc;
         nxt.latched_x    = index_x;
         nxt.latched_y    = index_y;
         nxt.pointer      = 16'h0000;
         nxt.work_address = 16'h0000;
         if (mode == coas_pkg::MODE_IMP || mode > coas_pkg::MODE_IZY) begin
            nxt.phase       = coas_pkg::PHASE_IDLE;
            res.status      = coas_pkg::STATUS_RESOLVED;
            res.next_pc     = operand_pc;
         end else begin
            nxt.phase           = coas_pkg::PHASE_OP1;
            res.request_address = operand_pc;
         end
      end else begin
         unique case (cur.phase)
            coas_pkg::PHASE_OP1: begin
               if (cur.active_mode == coas_pkg::MODE_IMM) begin
                  nxt.phase             = coas_pkg::PHASE_IDLE;
                  res.status            = coas_pkg::STATUS_RESOLVED;
                  res.effective_address = cur.fetch_pc;
                  res.operand_value     = read_data;
                  res.next_pc           = cur.fetch_pc + 16'd1;
               end else if (cur.active_mode == coas_pkg::MODE_REL) begin
                  nxt.phase           = coas_pkg::PHASE_IDLE;
                  res.status          = coas_pkg::STATUS_RESOLVED;
                  res.relative_offset = read_data;
                  res.next_pc         = cur.fetch_pc + 16'd1;
               end else if (cur.active_mode == coas_pkg::MODE_ZP
                            || cur.active_mode == coas_pkg::MODE_ZPX
                            || cur.active_mode == coas_pkg::MODE_ZPY) begin
                  if (cur.active_mode == coas_pkg::MODE_ZPX) begin
                     add = cur.latched_x;
                  end else if (cur.active_mode == coas_pkg::MODE_ZPY) begin
                     add = cur.latched_y;
                  end
                  nxt.work_address    = {8'h00, read_data + add};
                  nxt.phase           = coas_pkg::PHASE_VALUE;
                  res.request_address = {8'h00, read_data + add};
               end else if (cur.active_mode == coas_pkg::MODE_IZX
                            || cur.active_mode == coas_pkg::MODE_IZY) begin
                  if (cur.active_mode == coas_pkg::MODE_IZX) begin
                     add = cur.latched_x;
                  end
                  nxt.pointer         = {8'h00, read_data + add};
                  nxt.phase           = coas_pkg::PHASE_PTR_LO;
                  res.request_address = {8'h00, read_data + add};
               end else begin
                  nxt.work_address    = data_wide;
                  nxt.phase           = coas_pkg::PHASE_OP2;
                  res.request_address = cur.fetch_pc + 16'd1;
               end
            end
            coas_pkg::PHASE_OP2: begin
               if (cur.active_mode == coas_pkg::MODE_IND) begin
                  nxt.pointer         = base;
                  nxt.phase           = coas_pkg::PHASE_PTR_LO;
                  res.request_address = base;
               end else begin
                  if (cur.active_mode == coas_pkg::MODE_ABX) begin
                     add = cur.latched_x;
                  end else if (cur.active_mode == coas_pkg::MODE_ABY) begin
                     add = cur.latched_y;
                  end
                  addr                = base + {8'h00, add};
                  nxt.work_address    = addr;
                  nxt.phase           = coas_pkg::PHASE_VALUE;
                  res.request_address = addr;
               end
            end
            coas_pkg::PHASE_PTR_LO: begin
               nxt.work_address    = data_wide;
               nxt.phase           = coas_pkg::PHASE_PTR_HI;
               res.request_address = {cur.pointer[15:8], cur.pointer[7:0] + 8'd1};
            end
            coas_pkg::PHASE_PTR_HI: begin
               if (cur.active_mode == coas_pkg::MODE_IZY) begin
                  add = cur.latched_y;
               end
               addr                = base + {8'h00, add};
               nxt.work_address    = addr;
               nxt.phase           = coas_pkg::PHASE_VALUE;
               res.request_address = addr;
            end
            coas_pkg::PHASE_VALUE: begin
               if (cur.active_mode == coas_pkg::MODE_ABS
                   || cur.active_mode == coas_pkg::MODE_ABX
                   || cur.active_mode == coas_pkg::MODE_ABY
                   || cur.active_mode == coas_pkg::MODE_IND) begin
                  len = 2'd2;
               end else begin
                  len = 2'd1;
               end
               nxt.phase             = coas_pkg::PHASE_IDLE;
               res.status            = coas_pkg::STATUS_RESOLVED;
               res.effective_address = cur.work_address;
               res.operand_value     = read_data;
               res.next_pc           = cur.fetch_pc + {14'd0, len};
            end
            default: begin
               nxt.phase  = coas_pkg::PHASE_IDLE;
               res.status = coas_pkg::STATUS_UNEXPECTED;
            end
         endcase
      end
   end

endmodule
